FILE: hw/rtl/ppls_pkg.sv
// Package: shared widths, register indexes, reset values and pipeline types.
`default_nettype none
package ppls_pkg;

    localparam int POS_W          = 32;
    localparam int VEC_W          = 16;
    localparam int COL_W          = 16;
    localparam int EC_W           = 20;
    localparam int LC_W           = 48;
    localparam int COEF_W         = 16;
    localparam int SHININESS_W    = 10;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 48;
    localparam int SHINE_BITS_DEF = 10;
    localparam int ROOT_STAGES    = 32;
    localparam int DIV_STAGES     = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Z    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COLOR    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_COEFF  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_COEFF  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_COEFF = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SHININESS      = 4'd7;

    // Reset values
    localparam logic [LC_W-1:0]        LIGHT_COLOR_RST = 48'h1000_1000_1000;
    localparam logic [COEF_W-1:0]      AMBIENT_RST     = 16'd3277;
    localparam logic [COEF_W-1:0]      DIFFUSE_RST     = 16'd29491;
    localparam logic [COEF_W-1:0]      SPECULAR_RST    = 16'd29491;
    localparam logic [SHININESS_W-1:0] SHININESS_RST   = 10'd200;

    localparam logic [15:0] ONE_Q15 = 16'd32768;

    typedef logic signed [15:0] s16_t;
    typedef logic signed [16:0] s17_t;
    typedef logic signed [18:0] s19_t;
    typedef logic signed [21:0] s22_t;
    typedef logic signed [34:0] s35_t;
    typedef logic signed [35:0] s36_t;
    typedef logic signed [37:0] s38_t;
    typedef logic signed [39:0] s40_t;

    // Per-item data that rides along the whole pipeline
    typedef struct packed {
        s16_t [2:0]            eye;
        s16_t [2:0]            nrm;
        logic [2:0][EC_W-1:0]  ec;
        logic [2:0]            neg;
        logic                  zero;
    } carry_t;

    // Front end: light vector and sum of squares
    typedef struct packed {
        carry_t           c;
        logic [2:0][32:0] mag;
        logic [32:0]      orv;
        logic [5:0]       msb;
        logic [2:0][61:0] sq;
        logic [63:0]      sum;
    } fr_t;

    // Side data through the square root
    typedef struct packed {
        carry_t           c;
        logic [2:0][30:0] mag;
    } sq_side_t;

    // Back end: dot products, power and terms
    typedef struct packed {
        carry_t           c;
        s17_t [2:0]       lv;
        s38_t [2:0]       pr;
        s35_t             ln;
        s19_t             ldn;
        logic             lit;
        logic [18:0]      dfac;
        s36_t [2:0]       t;
        s22_t [2:0]       rv;
        s40_t             rde;
        logic             ok;
        logic [15:0]      p;
        logic [15:0]      base;
        logic [16:0]      sfac;
        logic [2:0][20:0] amb;
        logic [2:0][23:0] dif;
        logic [2:0][17:0] spc;
    } bk_t;

    // Index of the highest set bit
    function automatic logic [5:0] msb_index(input logic [32:0] v);
        logic [5:0] m;
        m = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (v[i])
                m = 6'(i);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ppls_if.sv
// Interfaces: pixel input channel, shade output channel, configuration write channel.
`default_nettype none
interface ppls_pixel_if import ppls_pkg::*; ();
    logic              valid;
    logic              ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] eye_x;
    logic signed [15:0] eye_y;
    logic signed [15:0] eye_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [COL_W-1:0]   color_r;
    logic [COL_W-1:0]   color_g;
    logic [COL_W-1:0]   color_b;

    modport source (output valid, point_x, point_y, point_z, eye_x, eye_y, eye_z,
                    normal_x, normal_y, normal_z, color_r, color_g, color_b,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, eye_x, eye_y, eye_z,
                  normal_x, normal_y, normal_z, color_r, color_g, color_b,
                  output ready);
endinterface

interface ppls_shade_if import ppls_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] shade_r;
    logic [COL_W-1:0] shade_g;
    logic [COL_W-1:0] shade_b;

    modport source (output valid, shade_r, shade_g, shade_b, input ready);
    modport sink (input valid, shade_r, shade_g, shade_b, output ready);
endinterface

interface ppls_cfg_if import ppls_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ppls_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module ppls_isqrt import ppls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [63:0] in_sum,
    input  sq_side_t    in_side,
    output logic        out_valid,
    output logic [31:0] out_root,
    output sq_side_t    out_side
);

    logic [ROOT_STAGES-1:0] v_reg;
    logic [31:0]            root_reg [ROOT_STAGES];
    logic [34:0]            rem_reg  [ROOT_STAGES];
    logic [63:0]            sum_reg  [ROOT_STAGES];
    sq_side_t               side_reg [ROOT_STAGES];
    logic [31:0]            root_next [ROOT_STAGES];
    logic [34:0]            rem_next  [ROOT_STAGES];

    // One digit of the root per stage, top bits first
    for (genvar j = 0; j < ROOT_STAGES; j++)
    begin : g_stage
        localparam int K = ROOT_STAGES - 1 - j;
        logic [31:0] prv_root;
        logic [34:0] prv_rem;
        logic [63:0] prv_sum;
        logic [34:0] rem_t;
        logic [34:0] trial;
        logic        ge;
        if (j == 0)
        begin : g_first
            assign prv_root = '0;
            assign prv_rem  = '0;
            assign prv_sum  = in_sum;
        end
        else
        begin : g_rest
            assign prv_root = root_reg[j-1];
            assign prv_rem  = rem_reg[j-1];
            assign prv_sum  = sum_reg[j-1];
        end
        assign rem_t = {prv_rem[32:0], prv_sum[2*K+1 -: 2]};
        assign trial = {1'b0, prv_root, 2'b01};
        assign ge    = (rem_t >= trial);
        assign rem_next[j]  = ge ? (rem_t - trial) : rem_t;
        assign root_next[j] = {prv_root[30:0], ge};
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[ROOT_STAGES-2:0], in_valid};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg[0]  <= in_sum;
            side_reg[0] <= in_side;
            for (int j = 0; j < ROOT_STAGES; j++)
            begin
                root_reg[j] <= root_next[j];
                rem_reg[j]  <= rem_next[j];
            end
            for (int j = 1; j < ROOT_STAGES; j++)
            begin
                sum_reg[j]  <= sum_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[ROOT_STAGES-1];
    assign out_root  = root_reg[ROOT_STAGES-1];
    assign out_side  = side_reg[ROOT_STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/ppls_div.sv
// Pipelined three-lane restoring divider: (mag << 15) / len, one quotient bit per stage.
`default_nettype none
module ppls_div import ppls_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [2:0][30:0] in_mag,
    input  logic [31:0]      in_len,
    input  carry_t           in_side,
    output logic             out_valid,
    output logic [2:0][15:0] out_quo,
    output carry_t           out_side
);

    logic [DIV_STAGES-1:0] v_reg;
    logic [31:0]           len_reg  [DIV_STAGES];
    logic [2:0][33:0]      r_reg    [DIV_STAGES];
    logic [2:0][15:0]      q_reg    [DIV_STAGES];
    carry_t                side_reg [DIV_STAGES];
    logic [2:0][33:0]      r_next   [DIV_STAGES];
    logic [2:0][15:0]      q_next   [DIV_STAGES];

    // One quotient bit per stage for each lane
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [31:0]      prv_len;
        logic [2:0][33:0] prv_r;
        logic [2:0][15:0] prv_q;
        if (s == 0)
        begin : g_first
            assign prv_len = in_len;
            assign prv_q   = '0;
            for (genvar i = 0; i < 3; i++)
            begin : g_ln
                assign prv_r[i] = 34'(in_mag[i]);
            end
        end
        else
        begin : g_rest
            assign prv_len = len_reg[s-1];
            assign prv_q   = q_reg[s-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_ln
                assign prv_r[i] = {r_reg[s-1][i][32:0], 1'b0};
            end
        end
        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic ge;
            assign ge = (prv_r[i] >= 34'(prv_len));
            assign r_next[s][i] = ge ? (prv_r[i] - 34'(prv_len)) : prv_r[i];
            always_comb
            begin
                q_next[s][i] = prv_q[i];
                q_next[s][i][DIV_STAGES-1-s] = ge;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[DIV_STAGES-2:0], in_valid};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len_reg[0]  <= in_len;
            side_reg[0] <= in_side;
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                r_reg[s] <= r_next[s];
                q_reg[s] <= q_next[s];
            end
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                len_reg[s]  <= len_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_quo   = q_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/phong_point_light_shader_unit.sv
// Phong point-light shader: fixed-point ambient, diffuse and specular per surface point.
//
// Channels: pixel takes one surface point per item (point Q16.16, eye and normal
// Q1.15, material color Q4.12); shade returns one saturated Q4.12 color per item;
// cfg writes the light position, light color, material coefficients and
// shininess by register index, one write per cycle, always ready.
// Throughput: one item per cycle while shade is taken. The pipeline length is set by
// the 32-stage square root, the 16-stage divider and one stage per shininess bit.
// Reset: all valid bits clear, configuration registers take their documented reset values.
// Stall: when shade is not taken, the whole pipeline holds and pixel.ready
// drops; nothing is lost or repeated. Configuration must only change while
// no item is in flight.
`default_nettype none
module phong_point_light_shader_unit import ppls_pkg::*;
#(
    parameter int SHINE_BITS = SHINE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    ppls_pixel_if.sink    pixel,
    ppls_shade_if.source  shade,
    ppls_cfg_if.sink      cfg
);

    localparam int NB = 10 + SHINE_BITS;

    logic signed [31:0]     light_pos_x_reg;
    logic signed [31:0]     light_pos_y_reg;
    logic signed [31:0]     light_pos_z_reg;
    logic [LC_W-1:0]        light_color_reg;
    logic [COEF_W-1:0]      ambient_coeff_reg;
    logic [COEF_W-1:0]      diffuse_coeff_reg;
    logic [COEF_W-1:0]      specular_coeff_reg;
    logic [SHININESS_W-1:0] shininess_reg;

    logic adv;
    logic out_valid_reg;
    logic [COL_W-1:0] shade_r_reg;
    logic [COL_W-1:0] shade_g_reg;
    logic [COL_W-1:0] shade_b_reg;
    logic [2:0][COL_W-1:0] sat_next;

    logic [2:0][15:0] lc;

    // Advance the whole pipeline unless the output is held
    assign adv         = !out_valid_reg || shade.ready;
    assign pixel.ready = adv;
    assign cfg.ready   = 1'b1;

    for (genvar i = 0; i < 3; i++)
    begin : g_lc
        assign lc[i] = light_color_reg[16*i +: 16];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_pos_x_reg    <= '0;
            light_pos_y_reg    <= '0;
            light_pos_z_reg    <= '0;
            light_color_reg    <= LIGHT_COLOR_RST;
            ambient_coeff_reg  <= AMBIENT_RST;
            diffuse_coeff_reg  <= DIFFUSE_RST;
            specular_coeff_reg <= SPECULAR_RST;
            shininess_reg      <= SHININESS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_LIGHT_POS_X:    light_pos_x_reg    <= cfg.data[31:0];
                REG_LIGHT_POS_Y:    light_pos_y_reg    <= cfg.data[31:0];
                REG_LIGHT_POS_Z:    light_pos_z_reg    <= cfg.data[31:0];
                REG_LIGHT_COLOR:    light_color_reg    <= cfg.data[LC_W-1:0];
                REG_AMBIENT_COEFF:  ambient_coeff_reg  <= cfg.data[COEF_W-1:0];
                REG_DIFFUSE_COEFF:  diffuse_coeff_reg  <= cfg.data[COEF_W-1:0];
                REG_SPECULAR_COEFF: specular_coeff_reg <= cfg.data[COEF_W-1:0];
                REG_SHININESS:      shininess_reg      <= cfg.data[SHININESS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- front end ----------------
    logic [5:0] fv_reg;
    fr_t fr0_reg, fr1_reg, fr2_reg, fr3_reg, fr4_reg, fr5_reg;
    fr_t fr0_next, fr1_next, fr2_next, fr3_next, fr4_next, fr5_next;

    // Light vector magnitudes and effective color
    always_comb
    begin
        logic signed [31:0] lp [3];
        logic signed [31:0] pt [3];
        logic [15:0]        col [3];
        logic signed [32:0] d;
        logic [31:0]        ecp;
        lp[0] = light_pos_x_reg;  lp[1] = light_pos_y_reg;  lp[2] = light_pos_z_reg;
        pt[0] = pixel.point_x;    pt[1] = pixel.point_y;    pt[2] = pixel.point_z;
        col[0] = pixel.color_r;   col[1] = pixel.color_g;   col[2] = pixel.color_b;
        fr0_next = '0;
        fr0_next.c.eye[0] = pixel.eye_x;
        fr0_next.c.eye[1] = pixel.eye_y;
        fr0_next.c.eye[2] = pixel.eye_z;
        fr0_next.c.nrm[0] = pixel.normal_x;
        fr0_next.c.nrm[1] = pixel.normal_y;
        fr0_next.c.nrm[2] = pixel.normal_z;
        for (int i = 0; i < 3; i++)
        begin
            d = 33'(lp[i]) - 33'(pt[i]);
            fr0_next.c.neg[i] = d[32];
            fr0_next.mag[i]   = d[32] ? 33'(-d) : 33'(d);
            ecp = 32'(col[i]) * 32'(lc[i]);
            fr0_next.c.ec[i]  = ecp[31:12];
        end
    end

    // Combine magnitudes for the leading-one search
    always_comb
    begin
        fr1_next     = fr0_reg;
        fr1_next.orv = fr0_reg.mag[0] | fr0_reg.mag[1] | fr0_reg.mag[2];
    end

    // Find the leading one of the largest magnitude
    always_comb
    begin
        fr2_next        = fr1_reg;
        fr2_next.msb    = msb_index(fr1_reg.orv);
        fr2_next.c.zero = (fr1_reg.orv == '0);
    end

    // Scale so the largest magnitude lands in [2^30, 2^31)
    always_comb
    begin
        logic [63:0] sh;
        fr3_next = fr2_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (fr2_reg.msb <= 6'd30)
                sh = 64'(fr2_reg.mag[i]) << (6'd30 - fr2_reg.msb);
            else
                sh = 64'(fr2_reg.mag[i]) >> (fr2_reg.msb - 6'd30);
            fr3_next.mag[i] = 33'(sh[30:0]);
        end
    end

    // Square each component
    always_comb
    begin
        fr4_next = fr3_reg;
        for (int i = 0; i < 3; i++)
            fr4_next.sq[i] = 62'(fr3_reg.mag[i][30:0]) * 62'(fr3_reg.mag[i][30:0]);
    end

    // Sum of squares
    always_comb
    begin
        fr5_next     = fr4_reg;
        fr5_next.sum = 64'(fr4_reg.sq[0]) + 64'(fr4_reg.sq[1]) + 64'(fr4_reg.sq[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else if (adv)
            fv_reg <= {fv_reg[4:0], pixel.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fr0_reg <= fr0_next;
            fr1_reg <= fr1_next;
            fr2_reg <= fr2_next;
            fr3_reg <= fr3_next;
            fr4_reg <= fr4_next;
            fr5_reg <= fr5_next;
        end
    end

    // ---------------- length and normalize ----------------
    sq_side_t         sq_side_in;
    sq_side_t         sq_side_out;
    logic             sq_valid;
    logic [31:0]      sq_root;
    logic             dv_valid;
    logic [2:0][15:0] dv_quo;
    carry_t           dv_side;

    always_comb
    begin
        sq_side_in.c = fr5_reg.c;
        for (int i = 0; i < 3; i++)
            sq_side_in.mag[i] = fr5_reg.mag[i][30:0];
    end

    ppls_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fv_reg[5]),
        .in_sum    (fr5_reg.sum),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_out)
    );

    ppls_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_mag    (sq_side_out.mag),
        .in_len    (sq_root),
        .in_side   (sq_side_out.c),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // ---------------- back end ----------------
    logic [NB-1:0] bv_reg;
    bk_t bk0_reg, bk1_reg, bk2_reg, bk3_reg, bk4_reg, bk5_reg, bk6_reg, bk7_reg;
    bk_t bk8_reg, bk9_reg;
    bk_t bk0_next, bk1_next, bk2_next, bk3_next, bk4_next, bk5_next, bk6_next, bk7_next;
    bk_t bk8_next, bk9_next;
    bk_t pw_reg  [SHINE_BITS];
    bk_t pw_next [SHINE_BITS];

    // Signed unit light vector
    always_comb
    begin
        bk0_next   = '0;
        bk0_next.c = dv_side;
        for (int i = 0; i < 3; i++)
        begin
            if (dv_side.zero)
                bk0_next.lv[i] = '0;
            else if (dv_side.neg[i])
                bk0_next.lv[i] = -17'(dv_quo[i]);
            else
                bk0_next.lv[i] = 17'(dv_quo[i]);
        end
    end

    // L times N per component
    always_comb
    begin
        bk1_next = bk0_reg;
        for (int i = 0; i < 3; i++)
            bk1_next.pr[i] = 38'(bk0_reg.lv[i]) * 38'(bk0_reg.c.nrm[i]);
    end

    // L dot N and its Q15 form
    always_comb
    begin
        s38_t s;
        bk2_next     = bk1_reg;
        s            = bk1_reg.pr[0] + bk1_reg.pr[1] + bk1_reg.pr[2];
        bk2_next.ln  = 35'(s);
        bk2_next.lit = !s[37];
        bk2_next.ldn = 19'(s >>> 15);
    end

    // Diffuse factor and doubled projection onto N
    always_comb
    begin
        logic [34:0] dprod;
        bk3_next = bk2_reg;
        dprod    = 35'(diffuse_coeff_reg) * 35'($unsigned(bk2_reg.ldn));
        bk3_next.dfac = bk2_reg.lit ? dprod[33:15] : '0;
        for (int i = 0; i < 3; i++)
            bk3_next.t[i] = (36'(bk2_reg.ldn) * 36'(bk2_reg.c.nrm[i])) <<< 1;
    end

    // Reflection vector
    always_comb
    begin
        bk4_next = bk3_reg;
        for (int i = 0; i < 3; i++)
            bk4_next.rv[i] = 22'(bk3_reg.t[i] >>> 15) - 22'(bk3_reg.lv[i]);
    end

    // R times E per component
    always_comb
    begin
        bk5_next = bk4_reg;
        for (int i = 0; i < 3; i++)
            bk5_next.pr[i] = 38'(bk4_reg.rv[i]) * 38'(bk4_reg.c.eye[i]);
    end

    // R dot E
    always_comb
    begin
        bk6_next     = bk5_reg;
        bk6_next.rde = 40'(bk5_reg.pr[0]) + 40'(bk5_reg.pr[1]) + 40'(bk5_reg.pr[2]);
    end

    // Clamp the specular base, start the power at 1.0
    always_comb
    begin
        s40_t rs;
        bk7_next    = bk6_reg;
        rs          = bk6_reg.rde >>> 15;
        bk7_next.ok = bk6_reg.lit && (bk6_reg.rde > 40'sd0);
        bk7_next.p  = ONE_Q15;
        if (rs > 40'sd32768)
            bk7_next.base = ONE_Q15;
        else
            bk7_next.base = rs[15:0];
    end

    // Square and multiply, one shininess bit per stage
    for (genvar b = 0; b < SHINE_BITS; b++)
    begin : g_pow
        bk_t  prv;
        logic sbit;
        if (b == 0)
        begin : g_first
            assign prv = bk7_reg;
        end
        else
        begin : g_rest
            assign prv = pw_reg[b-1];
        end
        if (b < SHININESS_W)
        begin : g_bit
            assign sbit = shininess_reg[b];
        end
        else
        begin : g_nobit
            assign sbit = 1'b0;
        end
        always_comb
        begin
            logic [31:0] pb;
            logic [31:0] bb;
            pw_next[b] = prv;
            pb = 32'(prv.p) * 32'(prv.base);
            bb = 32'(prv.base) * 32'(prv.base);
            if (sbit)
                pw_next[b].p = pb[30:15];
            pw_next[b].base = bb[30:15];
        end
    end

    // Specular factor
    always_comb
    begin
        logic [32:0] sp;
        bk8_next = pw_reg[SHINE_BITS-1];
        sp = 33'(specular_coeff_reg) * 33'(pw_reg[SHINE_BITS-1].p);
        bk8_next.sfac = pw_reg[SHINE_BITS-1].ok ? sp[31:15] : '0;
    end

    // Ambient, diffuse and specular terms per channel
    always_comb
    begin
        logic [35:0] ap;
        logic [38:0] dp;
        logic [32:0] spp;
        bk9_next = bk8_reg;
        for (int i = 0; i < 3; i++)
        begin
            ap  = 36'(bk8_reg.c.ec[i]) * 36'(ambient_coeff_reg);
            dp  = 39'(bk8_reg.c.ec[i]) * 39'(bk8_reg.dfac);
            spp = 33'(lc[i]) * 33'(bk8_reg.sfac);
            bk9_next.amb[i] = ap[35:15];
            bk9_next.dif[i] = dp[38:15];
            bk9_next.spc[i] = spp[32:15];
        end
    end

    // Sum and saturate
    always_comb
    begin
        logic [24:0] s;
        for (int i = 0; i < 3; i++)
        begin
            s = 25'(bk9_reg.amb[i]) + 25'(bk9_reg.dif[i]) + 25'(bk9_reg.spc[i]);
            sat_next[i] = (s > 25'd65535) ? 16'hFFFF : s[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            bv_reg        <= {bv_reg[NB-2:0], dv_valid};
            out_valid_reg <= bv_reg[NB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bk0_reg <= bk0_next;
            bk1_reg <= bk1_next;
            bk2_reg <= bk2_next;
            bk3_reg <= bk3_next;
            bk4_reg <= bk4_next;
            bk5_reg <= bk5_next;
            bk6_reg <= bk6_next;
            bk7_reg <= bk7_next;
            for (int b = 0; b < SHINE_BITS; b++)
                pw_reg[b] <= pw_next[b];
            bk8_reg     <= bk8_next;
            bk9_reg     <= bk9_next;
            shade_r_reg <= sat_next[0];
            shade_g_reg <= sat_next[1];
            shade_b_reg <= sat_next[2];
        end
    end

    assign shade.valid   = out_valid_reg;
    assign shade.shade_r = shade_r_reg;
    assign shade.shade_g = shade_g_reg;
    assign shade.shade_b = shade_b_reg;

endmodule
`default_nettype wire
